[design/tpsd_pkg.sv]
// tpsd_pkg: widths, codes and shared types of the three-phase sequence detector
// no dependencies; used by the interfaces, the serial divider, the top level and the testbench

package tpsd_pkg;

	// field widths
	localparam int TIME_W   = 32;
	localparam int PERIOD_W = 24;
	localparam int FREQ_W   = 16;
	localparam int TOL_W    = 12;
	localparam int ANGLE_W  = 16;
	localparam int IMB_W    = 15;
	localparam int CODE_W   = 2;

	// derived widths
	localparam int PSUM_W   = PERIOD_W + 2;     // sum of three periods
	localparam int DEVSUM_W = ANGLE_W + 1;      // sum of three deviations
	localparam int DEVX5_W  = DEVSUM_W + 2;     // deviation sum times five

	// serial divider widths
	localparam int DIV_NUM_W = PERIOD_W + ANGLE_W;  // product d * full turn
	localparam int DIV_W     = PERIOD_W;            // divisor and remainder
	localparam int DIV_QUO_W = PSUM_W;              // longest quotient that is read (mean)
	localparam int DIV_CNT_W = 6;

	// step counts of the divisions
	localparam logic [DIV_CNT_W-1:0] STEPS_MEAN  = DIV_CNT_W'(PSUM_W);
	localparam logic [DIV_CNT_W-1:0] STEPS_MOD   = DIV_CNT_W'(TIME_W);
	localparam logic [DIV_CNT_W-1:0] STEPS_ANGLE = DIV_CNT_W'(ANGLE_W);
	localparam logic [DIV_CNT_W-1:0] STEPS_IMB   = DIV_CNT_W'(DEVX5_W);

	// angle constants in hundredths of a degree
	localparam logic [ANGLE_W-1:0] FULL_TURN = 16'd36000;
	localparam logic [ANGLE_W-1:0] HALF_TURN = 16'd18000;
	localparam logic [ANGLE_W-1:0] DEG120    = 16'd12000;
	localparam logic [ANGLE_W-1:0] DEG240    = 16'd24000;

	// tolerance register
	localparam logic [TOL_W-1:0] TOL_RESET = 12'd1000;
	localparam logic [TOL_W-1:0] TOL_MIN   = 12'd1;
	localparam logic [TOL_W-1:0] TOL_MAX   = 12'd3000;

	// constant divisors
	localparam logic [DIV_W-1:0] DIV_BY_THREE    = 24'd3;
	localparam logic [DIV_W-1:0] DIV_BY_EIGHTEEN = 24'd18;

	// sequence codes
	localparam logic [CODE_W-1:0] SEQ_UNKNOWN = 2'd0;
	localparam logic [CODE_W-1:0] SEQ_ABC     = 2'd1;
	localparam logic [CODE_W-1:0] SEQ_ACB     = 2'd2;
	localparam logic [CODE_W-1:0] SEQ_ERROR   = 2'd3;

	// swap hint codes
	localparam logic [CODE_W-1:0] SWAP_NONE = 2'd0;
	localparam logic [CODE_W-1:0] SWAP_AB   = 2'd1;
	localparam logic [CODE_W-1:0] SWAP_BC   = 2'd2;
	localparam logic [CODE_W-1:0] SWAP_CA   = 2'd3;

	// divider request from the sequencer
	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;       // numerator, left aligned
		logic [DIV_W-1:0]     rem_init;  // starting partial remainder
		logic [DIV_W-1:0]     divisor;
		logic [DIV_CNT_W-1:0] steps;     // quotient bits to produce
	} div_req_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_QUO_W-1:0] quo;
		logic [DIV_W-1:0]     rem;
	} div_res_t;

endpackage

[design/tpsd_if.sv]
// tpsd interfaces: measurement request channel, result channel and tolerance write channel
// depends on tpsd_pkg for the field widths

interface tpsd_in_if;
	import tpsd_pkg::*;

	logic                valid;
	logic                ready;
	logic [TIME_W-1:0]   time_a;
	logic [TIME_W-1:0]   time_b;
	logic [TIME_W-1:0]   time_c;
	logic [PERIOD_W-1:0] period_a;
	logic [PERIOD_W-1:0] period_b;
	logic [PERIOD_W-1:0] period_c;
	logic [FREQ_W-1:0]   freq_a;
	logic [FREQ_W-1:0]   freq_b;
	logic [FREQ_W-1:0]   freq_c;
	logic                valid_a;
	logic                valid_b;
	logic                valid_c;

	modport source (
		output valid, time_a, time_b, time_c, period_a, period_b, period_c,
		       freq_a, freq_b, freq_c, valid_a, valid_b, valid_c,
		input  ready
	);
	modport sink (
		input  valid, time_a, time_b, time_c, period_a, period_b, period_c,
		       freq_a, freq_b, freq_c, valid_a, valid_b, valid_c,
		output ready
	);
endinterface

interface tpsd_out_if;
	import tpsd_pkg::*;

	logic               valid;
	logic               ready;
	logic               status;
	logic               results_valid;
	logic [CODE_W-1:0]  sequence_res;
	logic [ANGLE_W-1:0] angle_ab;
	logic [ANGLE_W-1:0] angle_bc;
	logic [ANGLE_W-1:0] angle_ca;
	logic [CODE_W-1:0]  swap_hint;
	logic               in_sync;
	logic [IMB_W-1:0]   imbalance;

	modport source (
		output valid, status, results_valid, sequence_res, angle_ab, angle_bc, angle_ca,
		       swap_hint, in_sync, imbalance,
		input  ready
	);
	modport sink (
		input  valid, status, results_valid, sequence_res, angle_ab, angle_bc, angle_ca,
		       swap_hint, in_sync, imbalance,
		output ready
	);
endinterface

interface tpsd_cfg_if;
	import tpsd_pkg::*;

	logic             valid;
	logic             ready;
	logic [TOL_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[design/tpsd_serial_div.sv]
// tpsd_serial_div: restoring divider, one quotient bit per cycle
// depends on tpsd_pkg for the request and status structs

module tpsd_serial_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tpsd_pkg::div_req_t req,
	output tpsd_pkg::div_res_t res
);
	import tpsd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_QUO_W-1:0] quo_q;
	logic [DIV_W-1:0]     div_q;

	logic [DIV_W:0]   rem_try;
	logic [DIV_W:0]   rem_sub;
	logic             fits;
	logic [DIV_W-1:0] rem_next;

	// trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		rem_try  = {rem_q, num_q[DIV_NUM_W-1]};
		rem_sub  = rem_try - {1'b0, div_q};
		fits     = (rem_try >= {1'b0, div_q});
		rem_next = fits ? rem_sub[DIV_W-1:0] : rem_try[DIV_W-1:0];
	end

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial result shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			num_q <= req.num;
			quo_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_QUO_W-2:0], fits};
		end
	end

	assign res.busy = busy_q;
	assign res.done = done_q;
	assign res.quo  = quo_q;
	assign res.rem  = rem_q;

endmodule

[design/three_phase_sequence_detector.sv]
// three_phase_sequence_detector: top level, sequencer, classification and held results
// depends on tpsd_pkg, the tpsd interfaces and tpsd_serial_div

// Takes one request of three phase timestamps, periods, frequencies and valid bits at a
// time and returns one result per request. The next request is taken only once a request
// with all phases valid has been through every division; all of them run on one shared
// bit-serial divider, 26 steps for the mean period, 32 + 16 steps for each of the three
// angles and 19 steps for the imbalance, plus the control states. A request with an invalid
// phase returns the held results with status 1. A new request is accepted while the
// previous result still waits in the output register. The angle tolerance is written over
// the cfg channel, which is always ready; values outside 1..3000 are dropped.

module three_phase_sequence_detector (
	input  logic       clk,
	input  logic       arst_n,
	tpsd_in_if.sink    sample,
	tpsd_out_if.source report,
	tpsd_cfg_if.sink   cfg
);
	import tpsd_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE      = 11'b000_0000_0001,
		S_MEAN_GO   = 11'b000_0000_0010,
		S_MEAN_WAIT = 11'b000_0000_0100,
		S_MOD_GO    = 11'b000_0000_1000,
		S_MOD_WAIT  = 11'b000_0001_0000,
		S_ANG_GO    = 11'b000_0010_0000,
		S_ANG_WAIT  = 11'b000_0100_0000,
		S_CLASS     = 11'b000_1000_0000,
		S_IMB_GO    = 11'b001_0000_0000,
		S_IMB_WAIT  = 11'b010_0000_0000,
		S_FIN       = 11'b100_0000_0000
	} state_t;

	// circular distance to a target within the tolerance
	function automatic logic near(input logic [ANGLE_W-1:0] x, input logic [ANGLE_W-1:0] t,
	                              input logic [TOL_W-1:0] tol);
		logic [ANGLE_W-1:0] d;
		d = (x >= t) ? x - t : t - x;
		if (d > HALF_TURN)
			d = (d < FULL_TURN) ? FULL_TURN - d : '0;
		return d <= {{(ANGLE_W-TOL_W){1'b0}}, tol};
	endfunction

	// distance to 120 degrees without wrap
	function automatic logic [ANGLE_W-1:0] dev120(input logic [ANGLE_W-1:0] x);
		return (x >= DEG120) ? x - DEG120 : DEG120 - x;
	endfunction

	state_t state_q;
	logic [1:0] k_q;

	// request capture
	logic [TIME_W-1:0]  ta_q, tb_q, tc_q;
	logic [PSUM_W-1:0]  psum_q;
	logic [FREQ_W-1:0]  fa_q, fb_q, fc_q;
	logic               status_q;

	// working registers
	logic [DIV_W-1:0]     mean_q;
	logic [DIV_NUM_W-1:0] prod_q;
	logic [DEVSUM_W-1:0]  devsum_q;

	// held results
	logic               tol_q;
	logic [TOL_W-1:0]   tol_val_q;
	logic               held_valid_q;
	logic [CODE_W-1:0]  held_seq_q;
	logic [ANGLE_W-1:0] held_ang_q [3];
	logic [CODE_W-1:0]  held_swap_q;
	logic               held_sync_q;
	logic [IMB_W-1:0]   held_imb_q;

	// output register
	logic               out_valid_q;
	logic               o_status_q;
	logic               o_rvalid_q;
	logic [CODE_W-1:0]  o_seq_q;
	logic [ANGLE_W-1:0] o_ab_q, o_bc_q, o_ca_q;
	logic [CODE_W-1:0]  o_swap_q;
	logic               o_sync_q;
	logic [IMB_W-1:0]   o_imb_q;

	div_req_t div_req;
	div_res_t div_res;

	logic                 accept;
	logic                 all_valid;
	logic                 out_free;
	logic [TIME_W-1:0]    pair_diff;
	logic [2:0]           is120;
	logic [2:0]           is240;
	logic [CODE_W-1:0]    seq_new;
	logic [CODE_W-1:0]    swap_new;
	logic [FREQ_W-1:0]    fmax, fmin;
	logic                 sync_new;
	logic [DEVSUM_W-1:0]  devsum_new;
	logic [DEVX5_W-1:0]   devx5;

	assign accept    = sample.valid && sample.ready;
	assign all_valid = sample.valid_a && sample.valid_b && sample.valid_c;
	assign out_free  = !out_valid_q || report.ready;

	tpsd_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	// timestamp difference of the current phase pair
	always_comb begin
		unique case (k_q)
			2'd0:    pair_diff = tb_q - ta_q;
			2'd1:    pair_diff = tc_q - tb_q;
			default: pair_diff = ta_q - tc_q;
		endcase
	end

	// sequence, swap hint and deviation from the fresh angles, sync from the frequencies
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			is120[i] = near(held_ang_q[i], DEG120, tol_val_q);
			is240[i] = near(held_ang_q[i], DEG240, tol_val_q) && !is120[i];
		end

		if (is120[0] && is120[1] && is120[2])
			seq_new = SEQ_ABC;
		else if (((is240[0] || is240[1]) && is120[2]) || (is240[0] && is240[1]))
			seq_new = SEQ_ACB;
		else
			seq_new = SEQ_ERROR;

		swap_new = SWAP_NONE;
		if (seq_new == SEQ_ACB)
			swap_new = SWAP_BC;
		else if (seq_new == SEQ_ERROR) begin
			priority if (is120[0] && is120[2])
				swap_new = SWAP_BC;
			else if (is120[1] && is120[2])
				swap_new = SWAP_AB;
			else if (is120[0] && is120[1])
				swap_new = SWAP_CA;
			else
				swap_new = SWAP_NONE;
		end

		fmax = (fa_q > fb_q) ? fa_q : fb_q;
		fmax = (fmax > fc_q) ? fmax : fc_q;
		fmin = (fa_q < fb_q) ? fa_q : fb_q;
		fmin = (fmin < fc_q) ? fmin : fc_q;
		sync_new = ((fmax - fmin) <= FREQ_W'(1));

		devsum_new = DEVSUM_W'(dev120(held_ang_q[0])) + DEVSUM_W'(dev120(held_ang_q[1]))
		           + DEVSUM_W'(dev120(held_ang_q[2]));
	end

	assign devx5 = {devsum_q, 2'b00} + DEVX5_W'(devsum_q);

	// divider requests issued by the sequencer
	always_comb begin
		div_req = '0;
		unique case (state_q)
			S_MEAN_GO: begin
				div_req.start   = 1'b1;
				div_req.num     = {psum_q, {(DIV_NUM_W-PSUM_W){1'b0}}};
				div_req.divisor = DIV_BY_THREE;
				div_req.steps   = STEPS_MEAN;
			end
			S_MOD_GO: begin
				div_req.start   = 1'b1;
				div_req.num     = {pair_diff, {(DIV_NUM_W-TIME_W){1'b0}}};
				div_req.divisor = mean_q;
				div_req.steps   = STEPS_MOD;
			end
			S_ANG_GO: begin
				div_req.start    = 1'b1;
				div_req.rem_init = prod_q[DIV_NUM_W-1:ANGLE_W];
				div_req.num      = {prod_q[ANGLE_W-1:0], {(DIV_NUM_W-ANGLE_W){1'b0}}};
				div_req.divisor  = mean_q;
				div_req.steps    = STEPS_ANGLE;
			end
			S_IMB_GO: begin
				div_req.start   = 1'b1;
				div_req.num     = {devx5, {(DIV_NUM_W-DEVX5_W){1'b0}}};
				div_req.divisor = DIV_BY_EIGHTEEN;
				div_req.steps   = STEPS_IMB;
			end
			default: div_req = '0;
		endcase
	end

	// sequencer, held results and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
			held_valid_q <= 1'b0;
			held_seq_q   <= SEQ_UNKNOWN;
			held_ang_q   <= '{default: '0};
			held_swap_q  <= SWAP_NONE;
			held_sync_q  <= 1'b0;
			held_imb_q   <= '0;
		end else begin
			if (report.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= all_valid ? S_MEAN_GO : S_FIN;
				end
				S_MEAN_GO:   state_q <= S_MEAN_WAIT;
				S_MEAN_WAIT: begin
					if (div_res.done) begin
						k_q     <= '0;
						state_q <= S_MOD_GO;
					end
				end
				S_MOD_GO:    state_q <= S_MOD_WAIT;
				S_MOD_WAIT: begin
					if (div_res.done)
						state_q <= S_ANG_GO;
				end
				S_ANG_GO:    state_q <= S_ANG_WAIT;
				S_ANG_WAIT: begin
					if (div_res.done) begin
						held_ang_q[k_q] <= (mean_q == '0) ? '0 : div_res.quo[ANGLE_W-1:0];
						if (k_q == 2'd2)
							state_q <= S_CLASS;
						else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_MOD_GO;
						end
					end
				end
				S_CLASS: begin
					held_seq_q  <= seq_new;
					held_swap_q <= swap_new;
					held_sync_q <= sync_new;
					state_q     <= S_IMB_GO;
				end
				S_IMB_GO:    state_q <= S_IMB_WAIT;
				S_IMB_WAIT: begin
					if (div_res.done) begin
						held_imb_q   <= div_res.quo[IMB_W-1:0];
						held_valid_q <= 1'b1;
						state_q      <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture and working payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ta_q     <= sample.time_a;
			tb_q     <= sample.time_b;
			tc_q     <= sample.time_c;
			psum_q   <= PSUM_W'(sample.period_a) + PSUM_W'(sample.period_b)
			          + PSUM_W'(sample.period_c);
			fa_q     <= sample.freq_a;
			fb_q     <= sample.freq_b;
			fc_q     <= sample.freq_c;
			status_q <= !all_valid;
		end
		if (state_q == S_MEAN_WAIT && div_res.done)
			mean_q <= div_res.quo[DIV_W-1:0];
		if (state_q == S_MOD_WAIT && div_res.done)
			prod_q <= DIV_NUM_W'(div_res.rem) * DIV_NUM_W'(FULL_TURN);
		if (state_q == S_CLASS)
			devsum_q <= devsum_new;
	end

	// output payload copied from the held results
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			o_status_q <= status_q;
			o_rvalid_q <= held_valid_q;
			o_seq_q    <= held_seq_q;
			o_ab_q     <= held_ang_q[0];
			o_bc_q     <= held_ang_q[1];
			o_ca_q     <= held_ang_q[2];
			o_swap_q   <= held_swap_q;
			o_sync_q   <= held_sync_q;
			o_imb_q    <= held_imb_q;
		end
	end

	// tolerance register, out-of-range writes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_val_q <= TOL_RESET;
			tol_q     <= 1'b0;
		end else begin
			tol_q <= cfg.valid;
			if (cfg.valid && cfg.data >= TOL_MIN && cfg.data <= TOL_MAX)
				tol_val_q <= cfg.data;
		end
	end

	assign cfg.ready    = 1'b1;
	assign sample.ready = (state_q == S_IDLE);

	assign report.valid         = out_valid_q;
	assign report.status        = o_status_q;
	assign report.results_valid = o_rvalid_q;
	assign report.sequence_res  = o_seq_q;
	assign report.angle_ab      = o_ab_q;
	assign report.angle_bc      = o_bc_q;
	assign report.angle_ca      = o_ca_q;
	assign report.swap_hint     = o_swap_q;
	assign report.in_sync       = o_sync_q;
	assign report.imbalance     = o_imb_q;

	// the sequencer never restarts the divider while it is still stepping
	assert property (@(posedge clk) disable iff (!arst_n) div_req.start |-> !div_res.busy)
		else $error("divider started while busy");

	// work begins only with an accepted request
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && !accept |=> (state_q == S_IDLE))
		else $error("sequencer left idle without a request");

	// held angles stay on the circle once a result exists
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) && held_valid_q |->
		(held_ang_q[0] < FULL_TURN) && (held_ang_q[1] < FULL_TURN) &&
		(held_ang_q[2] < FULL_TURN))
		else $error("held angle beyond a full turn");

	// the tolerance never leaves its legal range
	assert property (@(posedge clk) disable iff (!arst_n)
		tol_q |=> (tol_val_q >= TOL_MIN) && (tol_val_q <= TOL_MAX))
		else $error("tolerance register out of range");

endmodule

[test/three_phase_sequence_detector_tb.sv]
// three_phase_sequence_detector_tb: directed table and random phase sets against a local predictor
// depends on tpsd_pkg, the tpsd interfaces and the three_phase_sequence_detector top level

module three_phase_sequence_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tpsd_pkg::*;

	localparam int DIRECTED_ROWS    = 21;
	localparam int PHASES           = 9;
	localparam int SETS_PER_PHASE   = 78;
	localparam int LONG_HOLD_CYCLES = 800;
	localparam int DRAIN_CYCLES     = 20;
	localparam int CYCLE_LIMIT      = 1200000;

	// one measurement request as driven on the input channel
	typedef struct {
		logic [TIME_W-1:0]   time_a;
		logic [TIME_W-1:0]   time_b;
		logic [TIME_W-1:0]   time_c;
		logic [PERIOD_W-1:0] period_a;
		logic [PERIOD_W-1:0] period_b;
		logic [PERIOD_W-1:0] period_c;
		logic [FREQ_W-1:0]   freq_a;
		logic [FREQ_W-1:0]   freq_b;
		logic [FREQ_W-1:0]   freq_c;
		logic                valid_a;
		logic                valid_b;
		logic                valid_c;
	} phase_set_t;

	// one result as seen on the report channel
	typedef struct {
		logic               status;
		logic               results_valid;
		logic [CODE_W-1:0]  sequence_res;
		logic [ANGLE_W-1:0] angle_ab;
		logic [ANGLE_W-1:0] angle_bc;
		logic [ANGLE_W-1:0] angle_ca;
		logic [CODE_W-1:0]  swap_hint;
		logic               in_sync;
		logic [IMB_W-1:0]   imbalance;
	} report_t;

	logic clk;
	logic arst_n;

	tpsd_in_if  sample_if ();
	tpsd_out_if report_if ();
	tpsd_cfg_if cfg_if ();

	three_phase_sequence_detector DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if),
		.report (report_if),
		.cfg    (cfg_if)
	);

	// predictor copy of the tolerance and the held results
	logic [TOL_W-1:0]   tol_setting = TOL_RESET;
	logic               held_valid  = 1'b0;
	logic [CODE_W-1:0]  held_seq    = SEQ_UNKNOWN;
	logic [ANGLE_W-1:0] held_ab     = '0;
	logic [ANGLE_W-1:0] held_bc     = '0;
	logic [ANGLE_W-1:0] held_ca     = '0;
	logic [CODE_W-1:0]  held_swap   = SWAP_NONE;
	logic               held_sync   = 1'b0;
	logic [IMB_W-1:0]   held_imb    = '0;

	report_t     pending_reports[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned burst_left     = 0;
	bit          sender_calm    = 1'b0;
	bit          long_hold      = 1'b0;

	phase_set_t directed_sets[DIRECTED_ROWS];
	bit         directed_exact[DIRECTED_ROWS];
	report_t    directed_report[DIRECTED_ROWS];

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// angle in hundredths of a degree from the wrapped timestamp difference
	function automatic logic [ANGLE_W-1:0] phase_angle(logic [TIME_W-1:0] t1,
			logic [TIME_W-1:0] t2, longint unsigned mean);
		logic [TIME_W-1:0] diff;
		longint unsigned   d;
		if (mean == 0)
			return '0;
		diff = t2 - t1;
		d = diff;
		d = d % mean;
		return ANGLE_W'((d * FULL_TURN) / mean);
	endfunction

	// circular distance on a full turn within the tolerance
	function automatic bit angle_near(logic [ANGLE_W-1:0] x, logic [ANGLE_W-1:0] target);
		int unsigned span;
		span = (x >= target) ? x - target : target - x;
		if (span > HALF_TURN)
			span = (span < FULL_TURN) ? FULL_TURN - span : 0;
		return span <= tol_setting;
	endfunction

	function automatic int unsigned dev_from_120(logic [ANGLE_W-1:0] x);
		return (x >= DEG120) ? x - DEG120 : DEG120 - x;
	endfunction

	// expected report for one accepted request, updates the held results
	function automatic report_t detect_sequence(phase_set_t s);
		report_t         r;
		longint unsigned mean;
		int unsigned     fmax, fmin, dev_sum;
		logic [ANGLE_W-1:0] ab, bc, ca;
		bit              ab1, bc1, ca1, ab2, bc2;
		logic [CODE_W-1:0] seq, swap;
		r.status = 1'b1;
		if (s.valid_a && s.valid_b && s.valid_c) begin
			mean = s.period_a;
			mean += s.period_b;
			mean += s.period_c;
			mean = mean / 3;
			ab = phase_angle(s.time_a, s.time_b, mean);
			bc = phase_angle(s.time_b, s.time_c, mean);
			ca = phase_angle(s.time_c, s.time_a, mean);
			ab1 = angle_near(ab, DEG120);
			bc1 = angle_near(bc, DEG120);
			ca1 = angle_near(ca, DEG120);
			ab2 = angle_near(ab, DEG240) && !ab1;
			bc2 = angle_near(bc, DEG240) && !bc1;

			// classification
			if (ab1 && bc1 && ca1)
				seq = SEQ_ABC;
			else if (((ab2 || bc2) && ca1) || (ab2 && bc2))
				seq = SEQ_ACB;
			else
				seq = SEQ_ERROR;

			// swap hint
			swap = SWAP_NONE;
			if (seq == SEQ_ACB)
				swap = SWAP_BC;
			else if (seq == SEQ_ERROR) begin
				if (ab1 && ca1)
					swap = SWAP_BC;
				else if (bc1 && ca1)
					swap = SWAP_AB;
				else if (ab1 && bc1)
					swap = SWAP_CA;
			end

			// frequency spread
			fmax = s.freq_a;
			fmin = s.freq_a;
			if (s.freq_b > fmax) fmax = s.freq_b;
			if (s.freq_c > fmax) fmax = s.freq_c;
			if (s.freq_b < fmin) fmin = s.freq_b;
			if (s.freq_c < fmin) fmin = s.freq_c;

			dev_sum = dev_from_120(ab) + dev_from_120(bc) + dev_from_120(ca);
			held_valid = 1'b1;
			held_seq   = seq;
			held_ab    = ab;
			held_bc    = bc;
			held_ca    = ca;
			held_swap  = swap;
			held_sync  = (fmax - fmin) <= 1;
			held_imb   = IMB_W'((dev_sum * 5) / 18);
			r.status   = 1'b0;
		end
		r.results_valid = held_valid;
		r.sequence_res  = held_seq;
		r.angle_ab      = held_ab;
		r.angle_bc      = held_bc;
		r.angle_ca      = held_ca;
		r.swap_hint     = held_swap;
		r.in_sync       = held_sync;
		r.imbalance     = held_imb;
		return r;
	endfunction

	function automatic phase_set_t mk_set(logic [TIME_W-1:0] ta, logic [TIME_W-1:0] tb,
			logic [TIME_W-1:0] tc, logic [PERIOD_W-1:0] pa, logic [PERIOD_W-1:0] pb,
			logic [PERIOD_W-1:0] pc, logic [FREQ_W-1:0] fa, logic [FREQ_W-1:0] fb,
			logic [FREQ_W-1:0] fc, logic [2:0] valid_abc);
		phase_set_t s;
		s.time_a = ta;
		s.time_b = tb;
		s.time_c = tc;
		s.period_a = pa;
		s.period_b = pb;
		s.period_c = pc;
		s.freq_a = fa;
		s.freq_b = fb;
		s.freq_c = fc;
		{s.valid_a, s.valid_b, s.valid_c} = valid_abc;
		return s;
	endfunction

	function automatic report_t mk_report(logic st, logic rv, logic [CODE_W-1:0] seq,
			logic [ANGLE_W-1:0] ab, logic [ANGLE_W-1:0] bc, logic [ANGLE_W-1:0] ca,
			logic [CODE_W-1:0] swap, logic sync, logic [IMB_W-1:0] imb);
		report_t r;
		r.status = st;
		r.results_valid = rv;
		r.sequence_res = seq;
		r.angle_ab = ab;
		r.angle_bc = bc;
		r.angle_ca = ca;
		r.swap_hint = swap;
		r.in_sync = sync;
		r.imbalance = imb;
		return r;
	endfunction

	// random request: mostly well formed three phase sets, some noise
	function automatic phase_set_t random_set();
		phase_set_t      s;
		int unsigned     pick, mean, sum, pa, pb, f;
		int              jit, spread, ab_t, bc_t;
		longint unsigned off_ab, off_bc;
		pick = $urandom_range(0, 99);

		// noise over the full range of every field
		if (pick < 12) begin
			s.time_a = $urandom();
			s.time_b = $urandom();
			s.time_c = $urandom();
			s.period_a = PERIOD_W'($urandom());
			s.period_b = PERIOD_W'($urandom());
			s.period_c = PERIOD_W'($urandom());
			s.freq_a = FREQ_W'($urandom());
			s.freq_b = FREQ_W'($urandom());
			s.freq_c = FREQ_W'($urandom());
			{s.valid_a, s.valid_b, s.valid_c} = 3'($urandom());
			return s;
		end

		// power of two mean keeps the 2^32 wrap a whole number of turns
		mean = (pick < 80) ? (32'd1 << $urandom_range(4, 23)) : $urandom_range(1000, 50000);
		jit = (mean < 200) ? mean / 4 : 50;
		pa = mean + $urandom_range(0, 2 * jit) - jit;
		pb = mean + $urandom_range(0, 2 * jit) - jit;
		sum = 3 * mean + $urandom_range(0, 2);
		s.period_a = PERIOD_W'(pa);
		s.period_b = PERIOD_W'(pb);
		s.period_c = PERIOD_W'(sum - pa - pb);

		// frequencies within a couple of hertz
		f = $urandom_range(40, 70);
		if ($urandom_range(0, 9) == 0)
			f = $urandom_range(0, 65533);
		s.freq_a = FREQ_W'(f + $urandom_range(0, 2));
		s.freq_b = FREQ_W'(f + $urandom_range(0, 2));
		s.freq_c = FREQ_W'(f + $urandom_range(0, 2));

		// target angles, jittered around the tolerance edge
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			ab_t = DEG120;
			bc_t = DEG120;
		end else if (pick < 65) begin
			ab_t = DEG240;
			bc_t = DEG240;
		end else if (pick < 75) begin
			ab_t = DEG120;
			bc_t = DEG240;
		end else if (pick < 85) begin
			ab_t = DEG240;
			bc_t = DEG120;
		end else if (pick < 92) begin
			ab_t = DEG120;
			bc_t = $urandom_range(0, FULL_TURN - 1);
		end else begin
			ab_t = $urandom_range(0, FULL_TURN - 1);
			bc_t = $urandom_range(0, FULL_TURN - 1);
		end
		spread = tol_setting + tol_setting / 2 + 100;
		ab_t = ab_t + int'($urandom_range(0, 2 * spread)) - spread;
		bc_t = bc_t + int'($urandom_range(0, 2 * spread)) - spread;
		ab_t = ((ab_t % 36000) + 36000) % 36000;
		bc_t = ((bc_t % 36000) + 36000) % 36000;

		// timestamps, with a few whole periods added and the 2^32 wrap
		off_ab = ab_t;
		off_ab = (off_ab * mean) / FULL_TURN + $urandom_range(0, 3) * mean;
		off_bc = bc_t;
		off_bc = (off_bc * mean) / FULL_TURN + $urandom_range(0, 3) * mean;
		s.time_a = $urandom();
		s.time_b = s.time_a + TIME_W'(off_ab);
		s.time_c = s.time_b + TIME_W'(off_bc);

		{s.valid_a, s.valid_b, s.valid_c} = 3'b111;
		if ($urandom_range(0, 15) == 0)
			{s.valid_a, s.valid_b, s.valid_c} = 3'($urandom_range(0, 6));
		return s;
	endfunction

	// drive one request and wait until it is taken
	task automatic offer_set(phase_set_t s);
		sample_if.valid    <= 1'b1;
		sample_if.time_a   <= s.time_a;
		sample_if.time_b   <= s.time_b;
		sample_if.time_c   <= s.time_c;
		sample_if.period_a <= s.period_a;
		sample_if.period_b <= s.period_b;
		sample_if.period_c <= s.period_c;
		sample_if.freq_a   <= s.freq_a;
		sample_if.freq_b   <= s.freq_b;
		sample_if.freq_c   <= s.freq_c;
		sample_if.valid_a  <= s.valid_a;
		sample_if.valid_b  <= s.valid_b;
		sample_if.valid_c  <= s.valid_c;
		do @(posedge clk); while (sample_if.ready !== 1'b1);
	endtask

	task automatic idle_sender(int unsigned cycles);
		sample_if.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// bursts of requests with random gaps between them, no gaps while the sender is calm
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 220) : $urandom_range(1, 8);
			if (!sender_calm)
				idle_sender(gap);
		end
	endtask

	// stop sending and wait for every expected report
	task automatic wait_drained();
		sample_if.valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// receiver: random stalls, calm stretches and one long hold-off
	initial begin : receiver
		int unsigned stall_left;
		int unsigned calm_left;
		bit          calm;
		stall_left = 0;
		calm_left = 0;
		calm = 1'b0;
		forever begin
			if (long_hold) begin
				report_if.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				if (calm_left == 0) begin
					calm = ($urandom_range(0, 3) == 0);
					calm_left = $urandom_range(100, 1500);
				end else
					calm_left--;
				if (stall_left > 0) begin
					stall_left--;
					report_if.ready <= 1'b0;
				end else if (!calm && $urandom_range(0, 3) == 0) begin
					stall_left = $urandom_range(0, 9);
					report_if.ready <= 1'b0;
				end else
					report_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// compare each accepted report with the oldest expectation
	always @(posedge clk) begin : report_check
		report_t want;
		if (report_if.valid === 1'b1 && report_if.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				$error("report with no request outstanding");
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("status", want.status, report_if.status);
				check_field("results_valid", want.results_valid, report_if.results_valid);
				check_field("sequence_res", want.sequence_res, report_if.sequence_res);
				check_field("angle_ab", want.angle_ab, report_if.angle_ab);
				check_field("angle_bc", want.angle_bc, report_if.angle_bc);
				check_field("angle_ca", want.angle_ca, report_if.angle_ca);
				check_field("swap_hint", want.swap_hint, report_if.swap_hint);
				check_field("in_sync", want.in_sync, report_if.in_sync);
				check_field("imbalance", want.imbalance, report_if.imbalance);
			end
		end
	end

	// watchdog
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// main sequence
	initial begin : stimulus
		int               i;
		int               p;
		phase_set_t       s;
		report_t          predicted;
		logic [TOL_W-1:0] tol_plan[PHASES];

		arst_n = 1'b0;
		sample_if.valid = 1'b0;
		sample_if.time_a = '0;
		sample_if.time_b = '0;
		sample_if.time_c = '0;
		sample_if.period_a = '0;
		sample_if.period_b = '0;
		sample_if.period_c = '0;
		sample_if.freq_a = '0;
		sample_if.freq_b = '0;
		sample_if.freq_c = '0;
		sample_if.valid_a = 1'b0;
		sample_if.valid_b = 1'b0;
		sample_if.valid_c = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;

		// invalid phases right after reset report zeros
		directed_sets[0] = mk_set(0, 0, 0, 0, 0, 0, 0, 0, 0, 3'b000);
		directed_sets[1] = mk_set('1, '1, '1, '1, '1, '1, '1, '1, '1, 3'b011);
		directed_sets[2] = mk_set('1, 0, '1, 0, '1, 0, '1, 0, '1, 3'b101);
		directed_sets[3] = mk_set(0, '1, 0, '1, 0, '1, 0, '1, 0, 3'b110);
		for (i = 0; i < 4; i++) begin
			directed_exact[i] = 1'b1;
			directed_report[i] = mk_report(1'b1, 1'b0, SEQ_UNKNOWN, 0, 0, 0, SWAP_NONE, 1'b0, 0);
		end
		// zero mean period gives zero angles
		directed_sets[4] = mk_set('1, 0, '1, 0, 0, 0, 0, 0, 0, 3'b111);
		directed_exact[4] = 1'b1;
		directed_report[4] = mk_report(1'b0, 1'b1, SEQ_ERROR, 0, 0, 0, SWAP_NONE, 1'b1, 10000);
		// rejected request repeats the held results
		directed_sets[5] = mk_set('1, '1, '1, '1, '1, '1, '1, '1, '1, 3'b000);
		directed_exact[5] = 1'b1;
		directed_report[5] = mk_report(1'b1, 1'b1, SEQ_ERROR, 0, 0, 0, SWAP_NONE, 1'b1, 10000);
		// mean rounds down to zero, frequencies far apart
		directed_sets[6] = mk_set(100, 200, 300, 1, 1, 0, 0, '1, 0, 3'b111);
		directed_exact[6] = 1'b1;
		directed_report[6] = mk_report(1'b0, 1'b1, SEQ_ERROR, 0, 0, 0, SWAP_NONE, 1'b0, 10000);
		// mean of one, one hertz spread still in sync
		directed_sets[7] = mk_set(5, 7, 9, 1, 1, 1, 1, 0, 1, 3'b111);
		directed_exact[7] = 1'b1;
		directed_report[7] = mk_report(1'b0, 1'b1, SEQ_ERROR, 0, 0, 0, SWAP_NONE, 1'b1, 10000);
		// abc, acb and abc across the timestamp wrap
		directed_sets[8] = mk_set(0, 21845, 43690, 65536, 65536, 65536, 50, 50, 51, 3'b111);
		directed_sets[9] = mk_set(0, 43691, 87382, 65536, 65536, 65536, 50, 51, 50, 3'b111);
		directed_sets[10] = mk_set(32'hFFFF_C000, 32'hFFFF_C000 + 32'd21845,
			32'hFFFF_C000 + 32'd43690, 65536, 65536, 65537, 60, 60, 60, 3'b111);
		// largest periods
		directed_sets[11] = mk_set(0, '1, 32'h8000_0000, '1, '1, '1, '1, 16'hFFFE, '1, 3'b111);
		directed_sets[12] = mk_set(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, '1, 0, '1,
			1000, 1002, 1001, 3'b111);
		// error with each swap hint
		directed_sets[13] = mk_set(1000, 24484, 43053, 65536, 65536, 65536, 60, 60, 60, 3'b111);
		directed_sets[14] = mk_set(1000, 19569, 43053, 65536, 65536, 65536, 60, 60, 60, 3'b111);
		directed_sets[15] = mk_set(1000, 24484, 47968, 65536, 65536, 65536, 60, 60, 60, 3'b111);
		// acb from ab near 240 and ca near 120
		directed_sets[16] = mk_set(30000, 73691, 8155, 65536, 65536, 65536, 59, 60, 61, 3'b111);
		// equal timestamps on a non power of two period
		directed_sets[17] = mk_set(777, 777, 777, 20000, 20000, 20000, 50, 50, 50, 3'b111);
		directed_sets[18] = mk_set(1, 2, 3, 4, 5, 6, 7, 8, 9, 3'b001);
		directed_sets[19] = mk_set('1, 0, 32'h5555_5555, 20000, 20001, 20002, '1, '1, '1, 3'b111);
		directed_sets[20] = mk_set(9, 8, 7, 6, 5, 4, 3, 2, 1, 3'b100);

		tol_plan = '{12'd3000, 12'd1, 12'd0, 12'd1000, 12'd4095, 12'd2048, 12'd3001, 12'd250,
			TOL_W'($urandom_range(1, 3000))};

		// reset
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed table at the reset tolerance
		for (i = 0; i < DIRECTED_ROWS; i++) begin
			pace_sender();
			offer_set(directed_sets[i]);
			predicted = detect_sequence(directed_sets[i]);
			pending_reports.push_back(directed_exact[i] ? directed_report[i] : predicted);
		end

		// random phases, each with its own tolerance write
		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			cfg_if.valid <= 1'b1;
			cfg_if.data  <= tol_plan[p];
			do @(posedge clk); while (cfg_if.ready !== 1'b1);
			cfg_if.valid <= 1'b0;
			if (tol_plan[p] >= TOL_MIN && tol_plan[p] <= TOL_MAX)
				tol_setting = tol_plan[p];
			sender_calm = (p == 4);
			for (i = 0; i < SETS_PER_PHASE; i++) begin
				if (p == 2 && i == 10)
					long_hold = 1'b1;
				s = random_set();
				pace_sender();
				offer_set(s);
				pending_reports.push_back(detect_sequence(s));
			end
		end

		// drain and let any stray report show up
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
design/tpsd_pkg.sv
design/tpsd_if.sv
design/tpsd_serial_div.sv
design/three_phase_sequence_detector.sv
test/three_phase_sequence_detector_tb.sv
